FILE: src/lbmcol_pkg.sv
// ============================================================================
// lbmcol_pkg
// Shared types, direction tables and arithmetic helpers for the D2Q9 BGK
// collision pipeline.
// ============================================================================
package lbmcol_pkg;

  localparam int NDIR = 9;

  // Cell kinds as carried on the input tuser.
  localparam logic [1:0] KIND_FLUID  = 2'd0;
  localparam logic [1:0] KIND_SOLID  = 2'd1;
  localparam logic [1:0] KIND_INLET  = 2'd2;
  localparam logic [1:0] KIND_OUTLET = 2'd3;

  // Lattice directions in the order rest, E, N, W, S, NE, NW, SW, SE.
  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

  // Weights in units of 1/36.
  localparam int WNUM [NDIR] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};

  // Reciprocal of nine: ceil(2^39 / 9), exact for dividends below 2^39.
  localparam logic [35:0] RECIP9     = 36'd61083979321;
  localparam int          RECIP9_SHR = 39;

  // Dividend ceiling for the weight division: nine times 2^32.
  localparam logic [35:0] WDIV_CLAMP = 36'd38654705664;

  // Passenger word carried alongside the velocity divider.
  localparam int TAG_W = 321;

  // Number of register stages in one relaxation lane.
  localparam int LANE_LAT = 12;

  localparam logic [16:0] RELAX_RESET = 17'd65536;

  // Inputs of one relaxation lane, presented together with the velocity.
  typedef struct packed {
    logic               fluid;
    logic signed [31:0] dens;
    logic signed [31:0] pop;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
  } lane_in_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/lbm_d2q9_bgk_collision_unit.sv
// ============================================================================
// lbm_d2q9_bgk_collision_unit
// D2Q9 BGK collision for one lattice cell per beat, fully pipelined.
// ============================================================================
// Throughput: one cell per cycle; the 33 one-bit stages of the velocity
// divider set most of the depth. A stalled output freezes every stage.
// Reset (rst_n low at a clock edge) empties the pipeline and sets relax_rate
// back to 1.0 (65536).
// ============================================================================
module lbm_d2q9_bgk_collision_unit #(
  parameter int FRAC_BITS = 28
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // pop_0 .. pop_8, 32 bits each, pop_0 lowest
  input  logic [1:0]   in_tuser,   // cell_kind
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [383:0] out_tdata,  // new_pop_0 .. new_pop_8, density, vel_x, vel_y
  // Relaxation rate register.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data
);

  localparam int NDIR = lbmcol_pkg::NDIR;
  localparam int LL   = lbmcol_pkg::LANE_LAT;

  // The whole pipeline advances together. It moves whenever the output
  // register is empty or its beat is being taken, so bubbles never block.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // The register is written whenever offered; the block is idle by contract.
  logic [16:0] omega_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omega_r <= lbmcol_pkg::RELAX_RESET;
    end else if (cfg_valid) begin
      omega_r <= cfg_data;
    end
  end

  // Stage 1: input register.
  logic               v_s1_r;
  logic               fluid_s1_r;
  logic signed [31:0] pop_s1_r [NDIR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1_r <= 1'b0;
    end else if (en) begin
      v_s1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fluid_s1_r <= (in_tuser == lbmcol_pkg::KIND_FLUID);
      for (int i = 0; i < NDIR; i++) begin
        pop_s1_r[i] <= in_tdata[32*i +: 32];
      end
    end
  end

  // Stage 2: density and momentum sums at full width.
  logic signed [35:0] rho_nxt;
  logic signed [34:0] mx_nxt, my_nxt;

  always_comb begin
    rho_nxt = '0;
    for (int i = 0; i < NDIR; i++) begin
      rho_nxt = rho_nxt + 36'(pop_s1_r[i]);
    end
    mx_nxt = 35'(pop_s1_r[1]) - 35'(pop_s1_r[3]) + 35'(pop_s1_r[5])
           - 35'(pop_s1_r[6]) - 35'(pop_s1_r[7]) + 35'(pop_s1_r[8]);
    my_nxt = 35'(pop_s1_r[2]) - 35'(pop_s1_r[4]) + 35'(pop_s1_r[5])
           + 35'(pop_s1_r[6]) - 35'(pop_s1_r[7]) - 35'(pop_s1_r[8]);
  end

  logic               v_s2_r;
  logic               fluid_s2_r;
  logic signed [35:0] rho_s2_r;
  logic signed [34:0] mx_s2_r, my_s2_r;
  logic [287:0]       pops_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s2_r <= 1'b0;
    end else if (en) begin
      v_s2_r <= v_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fluid_s2_r <= fluid_s1_r;
      rho_s2_r   <= rho_nxt;
      mx_s2_r    <= mx_nxt;
      my_s2_r    <= my_nxt;
      for (int i = 0; i < NDIR; i++) begin
        pops_s2_r[32*i +: 32] <= pop_s1_r[i];
      end
    end
  end

  // Velocity divider; the populations, saturated density and kind ride along.
  logic [lbmcol_pkg::TAG_W-1:0] tag_in, tag_out;
  logic                         dv_valid;
  logic signed [31:0]           dv_ux, dv_uy;

  assign tag_in = {fluid_s2_r, lbmcol_pkg::sat32(64'(rho_s2_r)), pops_s2_r};

  lbmcol_vel_div #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (lbmcol_pkg::TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_s2_r),
    .in_rho    (rho_s2_r),
    .in_mx     (mx_s2_r),
    .in_my     (my_s2_r),
    .in_tag    (tag_in),
    .out_valid (dv_valid),
    .out_ux    (dv_ux),
    .out_uy    (dv_uy),
    .out_tag   (tag_out)
  );

  logic               dv_fluid;
  logic signed [31:0] dv_dens;

  assign dv_fluid = tag_out[320];
  assign dv_dens  = tag_out[319:288];

  // Squared speed, two stages, arriving as the lanes need it.
  logic signed [63:0] sqx_r, sqy_r;
  logic        [63:0] usq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= 64'(dv_ux) * 64'(dv_ux);
      sqy_r <= 64'(dv_uy) * 64'(dv_uy);
      usq_r <= ($unsigned(sqx_r) + $unsigned(sqy_r)) >> FRAC_BITS;
    end
  end

  // Nine relaxation lanes.
  logic signed [31:0] lane_out [NDIR];

  for (genvar d = 0; d < NDIR; d++) begin : g_lane
    lbmcol_pkg::lane_in_t lin;

    assign lin.fluid = dv_fluid;
    assign lin.dens  = dv_dens;
    assign lin.pop   = tag_out[32*d +: 32];
    assign lin.ux    = dv_ux;
    assign lin.uy    = dv_uy;

    lbmcol_relax_lane #(
      .FRAC_BITS (FRAC_BITS),
      .DIR       (d)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .lin     (lin),
      .usq     (usq_r),
      .omega   (omega_r),
      .new_pop (lane_out[d])
    );
  end

  // Side line for valid and the moment outputs, matched to the lane depth.
  // Non-fluid cells report zero density and velocity.
  logic               md_v_r     [0:LL-1];
  logic               md_fluid_r [0:LL-1];
  logic signed [31:0] md_dens_r  [0:LL-1];
  logic signed [31:0] md_ux_r    [0:LL-1];
  logic signed [31:0] md_uy_r    [0:LL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LL; i++) begin
        md_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      md_v_r[0] <= dv_valid;
      for (int i = 1; i < LL; i++) begin
        md_v_r[i] <= md_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_fluid_r[0] <= dv_fluid;
      md_dens_r[0]  <= dv_fluid ? dv_dens : 32'sd0;
      md_ux_r[0]    <= dv_fluid ? dv_ux : 32'sd0;
      md_uy_r[0]    <= dv_fluid ? dv_uy : 32'sd0;
      for (int i = 1; i < LL; i++) begin
        md_fluid_r[i] <= md_fluid_r[i-1];
        md_dens_r[i]  <= md_dens_r[i-1];
        md_ux_r[i]    <= md_ux_r[i-1];
        md_uy_r[i]    <= md_uy_r[i-1];
      end
    end
  end

  assign out_tvalid = md_v_r[LL-1];

  always_comb begin
    for (int i = 0; i < NDIR; i++) begin
      out_tdata[32*i +: 32] = lane_out[i];
    end
    out_tdata[319:288] = md_dens_r[LL-1];
    out_tdata[351:320] = md_ux_r[LL-1];
    out_tdata[383:352] = md_uy_r[LL-1];
  end

  // A non-fluid cell never reports density or velocity.
  a_nonfluid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !md_fluid_r[LL-1] |->
      out_tdata[319:288] == 32'd0 && out_tdata[351:320] == 32'd0 &&
      out_tdata[383:352] == 32'd0)
    else $error("non-fluid cell reported non-zero moments");

  // Zero density in a fluid cell gives zero velocity.
  a_zero_rho_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && md_fluid_r[LL-1] && out_tdata[319:288] == 32'd0 |->
      out_tdata[351:320] == 32'd0 && out_tdata[383:352] == 32'd0)
    else $error("zero density gave non-zero velocity");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !v_s1_r && !dv_valid)
    else $error("pipeline not empty after reset");

  // An accepted beat always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_s1_r)
    else $error("accepted beat lost at the input stage");

endmodule

FILE: src/lbmcol_vel_div.sv
// ============================================================================
// lbmcol_vel_div
// Pipelined restoring divider forming x and y velocity as momentum over
// density, one quotient bit per stage, truncated and saturated to 32 bits.
// ============================================================================
module lbmcol_vel_div #(
  parameter int FRAC_BITS = 28,
  parameter int TAG_W     = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [35:0]      in_rho,
  input  logic signed [34:0]      in_mx,
  input  logic signed [34:0]      in_my,
  input  logic        [TAG_W-1:0] in_tag,
  output logic                    out_valid,
  output logic signed [31:0]      out_ux,
  output logic signed [31:0]      out_uy,
  output logic        [TAG_W-1:0] out_tag
);

  localparam int AW = 34;
  localparam int BW = 35;
  localparam int QB = 33;
  localparam int NW = AW + FRAC_BITS;

  // Magnitude stage.
  logic              v0_r;
  logic [AW-1:0]     ax0_r, ay0_r;
  logic [BW-1:0]     b0_r;
  logic              nx0_r, ny0_r, z0_r;
  logic [TAG_W-1:0]  tag0_r;

  logic signed [34:0] mx_neg, my_neg;
  logic signed [35:0] rho_neg;

  assign mx_neg  = -in_mx;
  assign my_neg  = -in_my;
  assign rho_neg = -in_rho;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r  <= in_mx[34] ? mx_neg[AW-1:0] : in_mx[AW-1:0];
      ay0_r  <= in_my[34] ? my_neg[AW-1:0] : in_my[AW-1:0];
      b0_r   <= in_rho[35] ? rho_neg[BW-1:0] : in_rho[BW-1:0];
      nx0_r  <= in_mx[34] ^ in_rho[35];
      ny0_r  <= in_my[34] ^ in_rho[35];
      z0_r   <= (in_rho == 36'sd0);
      tag0_r <= in_tag;
    end
  end

  // Iteration stages; index 0 holds the initial partial remainder.
  logic              v_r   [0:QB];
  logic [BW-1:0]     rx_r  [0:QB];
  logic [BW-1:0]     ry_r  [0:QB];
  logic [QB-1:0]     qx_r  [0:QB];
  logic [QB-1:0]     qy_r  [0:QB];
  logic [QB-1:0]     lox_r [0:QB];
  logic [QB-1:0]     loy_r [0:QB];
  logic [BW-1:0]     b_r   [0:QB];
  logic              bgx_r [0:QB];
  logic              bgy_r [0:QB];
  logic              nx_r  [0:QB];
  logic              ny_r  [0:QB];
  logic              z_r   [0:QB];
  logic [TAG_W-1:0]  tag_r [0:QB];

  // The quotient of (a << FRAC_BITS) / b reaches 2^33 exactly when the bits
  // above the low 33 of the dividend are already no smaller than b.
  logic [NW-1:0] nx_full, ny_full, hix, hiy, bext;
  logic          bigx, bigy;

  assign nx_full = {ax0_r, {FRAC_BITS{1'b0}}};
  assign ny_full = {ay0_r, {FRAC_BITS{1'b0}}};
  assign hix     = nx_full >> QB;
  assign hiy     = ny_full >> QB;
  assign bext    = NW'(b0_r);
  assign bigx    = (hix >= bext);
  assign bigy    = (hiy >= bext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]  <= bigx ? '0 : hix[BW-1:0];
      ry_r[0]  <= bigy ? '0 : hiy[BW-1:0];
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      lox_r[0] <= nx_full[QB-1:0];
      loy_r[0] <= ny_full[QB-1:0];
      b_r[0]   <= b0_r;
      bgx_r[0] <= bigx;
      bgy_r[0] <= bigy;
      nx_r[0]  <= nx0_r;
      ny_r[0]  <= ny0_r;
      z_r[0]   <= z0_r;
      tag_r[0] <= tag0_r;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [BW:0] tx, ty;
    logic        gx, gy;

    assign tx = {rx_r[j-1], lox_r[j-1][QB-j]};
    assign ty = {ry_r[j-1], loy_r[j-1][QB-j]};
    assign gx = (tx >= {1'b0, b_r[j-1]});
    assign gy = (ty >= {1'b0, b_r[j-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[j]  <= gx ? BW'(tx - {1'b0, b_r[j-1]}) : tx[BW-1:0];
        ry_r[j]  <= gy ? BW'(ty - {1'b0, b_r[j-1]}) : ty[BW-1:0];
        qx_r[j]  <= {qx_r[j-1][QB-2:0], gx};
        qy_r[j]  <= {qy_r[j-1][QB-2:0], gy};
        lox_r[j] <= lox_r[j-1];
        loy_r[j] <= loy_r[j-1];
        b_r[j]   <= b_r[j-1];
        bgx_r[j] <= bgx_r[j-1];
        bgy_r[j] <= bgy_r[j-1];
        nx_r[j]  <= nx_r[j-1];
        ny_r[j]  <= ny_r[j-1];
        z_r[j]   <= z_r[j-1];
        tag_r[j] <= tag_r[j-1];
      end
    end
  end

  function automatic logic signed [31:0] vel_sat(input logic [QB-1:0] q, input logic big,
                                                 input logic neg, input logic zero);
    logic signed [33:0] qs;
    logic signed [33:0] qn;
    logic signed [31:0] r;
    qs = {1'b0, q};
    qn = -qs;
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (big || q > 33'h07fffffff) ? 32'sh7fffffff : q[31:0];
    end else begin
      r = (big || q > 33'h080000000) ? 32'sh80000000 : qn[31:0];
    end
    return r;
  endfunction

  logic              vo_r;
  logic signed [31:0] ux_r, uy_r;
  logic [TAG_W-1:0]  tago_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r   <= vel_sat(qx_r[QB], bgx_r[QB], nx_r[QB], z_r[QB]);
      uy_r   <= vel_sat(qy_r[QB], bgy_r[QB], ny_r[QB], z_r[QB]);
      tago_r <= tag_r[QB];
    end
  end

  assign out_valid = vo_r;
  assign out_ux    = ux_r;
  assign out_uy    = uy_r;
  assign out_tag   = tago_r;

endmodule

FILE: src/lbmcol_relax_lane.sv
// ============================================================================
// lbmcol_relax_lane
// One lattice direction: equilibrium from density and velocity, then BGK
// relaxation of the population, in twelve register stages.
// ============================================================================
module lbmcol_relax_lane #(
  parameter int FRAC_BITS = 28,
  parameter int DIR       = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  lbmcol_pkg::lane_in_t  lin,
  input  logic [63:0]           usq,
  input  logic [16:0]           omega,
  output logic signed [31:0]    new_pop
);

  localparam int CX = lbmcol_pkg::DIR_X[DIR];
  localparam int CY = lbmcol_pkg::DIR_Y[DIR];
  localparam int WN = lbmcol_pkg::WNUM[DIR];

  // Side pipes for the population, the cell kind and the density.
  logic signed [31:0] pop_p_r   [0:10];
  logic               fluid_p_r [0:10];
  logic signed [31:0] dens_p_r  [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      pop_p_r[0]   <= lin.pop;
      fluid_p_r[0] <= lin.fluid;
      dens_p_r[0]  <= lin.dens;
      for (int i = 1; i <= 10; i++) begin
        pop_p_r[i]   <= pop_p_r[i-1];
        fluid_p_r[i] <= fluid_p_r[i-1];
      end
      for (int i = 1; i <= 3; i++) begin
        dens_p_r[i] <= dens_p_r[i-1];
      end
    end
  end

  // Stage 1: projected velocity.
  logic signed [33:0] tx, ty;
  logic signed [31:0] uc_r;

  always_comb begin
    tx = '0;
    ty = '0;
    if (CX == 1) begin
      tx = 34'(lin.ux);
    end else if (CX == -1) begin
      tx = -34'(lin.ux);
    end
    if (CY == 1) begin
      ty = 34'(lin.uy);
    end else if (CY == -1) begin
      ty = -34'(lin.uy);
    end
  end

  // Stage 2: its square.
  logic signed [63:0] ucsq_r;
  logic signed [31:0] uc_d_r;

  // Stage 3 and 4: the bracket 1 + 3uc + 4.5uc^2 - 1.5|u|^2.
  logic        [63:0] uc2, a9, b3;
  logic signed [63:0] t1_r, t2_r;
  logic signed [31:0] br_r;

  assign uc2 = $unsigned(ucsq_r) >> FRAC_BITS;
  assign a9  = (uc2 * 64'd9) >> 1;
  assign b3  = (usq * 64'd3) >> 1;

  // Stage 5 and 6: density times bracket, then magnitude of the weighted value.
  logic signed [63:0] prod_r, xs;
  logic        [63:0] ax, sc;
  logic        [35:0] n_r;
  logic               neg_r;

  assign xs = prod_r >>> FRAC_BITS;
  assign ax = xs[63] ? $unsigned(-xs) : $unsigned(xs);

  always_comb begin
    if (WN == 16) begin
      sc = ax << 2;
    end else if (WN == 4) begin
      sc = ax;
    end else begin
      sc = ax >> 2;
    end
  end

  // Stage 7 to 9: division by nine through the reciprocal, in two halves.
  logic [53:0] ph_r, pl_r;
  logic        neg7_r, neg8_r;
  logic [72:0] qsum;
  logic [32:0] q_r;
  logic signed [33:0] qs, qn;
  logic signed [31:0] feq_r;

  assign qsum = {1'b0, ph_r, 18'b0} + 73'(pl_r);
  assign qs   = {1'b0, q_r};
  assign qn   = -qs;

  // Stage 10 to 12: relaxation toward the equilibrium.
  logic signed [32:0] diff_r;
  logic signed [50:0] rel_r;
  logic signed [63:0] nv;
  logic signed [31:0] out_r;

  assign nv = 64'(pop_p_r[10]) + 64'(rel_r >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      uc_r   <= lbmcol_pkg::sat32(64'(tx) + 64'(ty));
      ucsq_r <= 64'(uc_r) * 64'(uc_r);
      uc_d_r <= uc_r;
      t1_r   <= (64'sd1 <<< FRAC_BITS) + 64'(uc_d_r) * 64'sd3;
      t2_r   <= $signed(a9) - $signed(b3);
      br_r   <= lbmcol_pkg::sat32(t1_r + t2_r);
      prod_r <= 64'(dens_p_r[3]) * 64'(br_r);
      n_r    <= (sc > 64'(lbmcol_pkg::WDIV_CLAMP)) ? lbmcol_pkg::WDIV_CLAMP : sc[35:0];
      neg_r  <= xs[63];
      ph_r   <= 54'(n_r[35:18]) * 54'(lbmcol_pkg::RECIP9);
      pl_r   <= 54'(n_r[17:0]) * 54'(lbmcol_pkg::RECIP9);
      neg7_r <= neg_r;
      q_r    <= qsum[lbmcol_pkg::RECIP9_SHR +: 33];
      neg8_r <= neg7_r;
      if (neg8_r) begin
        feq_r <= (q_r > 33'h080000000) ? 32'sh80000000 : qn[31:0];
      end else begin
        feq_r <= (q_r > 33'h07fffffff) ? 32'sh7fffffff : q_r[31:0];
      end
      diff_r <= 33'(feq_r) - 33'(pop_p_r[8]);
      rel_r  <= 51'($signed({1'b0, omega})) * 51'(diff_r);
      out_r  <= fluid_p_r[10] ? lbmcol_pkg::sat32(nv) : pop_p_r[10];
    end
  end

  assign new_pop = out_r;

endmodule
